[rtl/assert_macros.svh]
// Assertion macros shared by the timing wheel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define HTW_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define HTW_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HTW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HTW_ASSERT_ALWAYS(lbl, cond)
`define HTW_ASSERT_IMPLY(lbl, ante, cons)
`define HTW_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/htw_pkg.sv]
// Package: constants, codes and control types of the hashed timing wheel.
`default_nettype none
package htw_pkg;
    localparam int MaxTimers     = 16;
    localparam int MaxWheelSlots = 1024;
    localparam int DelayW        = 24;
    localparam int TickW         = 16;
    localparam int SizeW         = 11;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_CREATE  = 3'd1;
    localparam logic [2:0] OP_RESCHED = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_CREATE  = 2'd1;
    localparam logic [1:0] PEND_RESCHED = 2'd2;
    localparam logic [1:0] PEND_DELETE  = 2'd3;

    localparam logic REG_SLOT_COUNT    = 1'b0;
    localparam logic REG_TICK_INTERVAL = 1'b1;

    localparam logic [SizeW-1:0] WheelSizeReset = 11'd60;
    localparam logic [TickW-1:0] TickReset      = 16'd1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_MUL   = 10'b0000000010,
        ST_ADD   = 10'b0000000100,
        ST_SCAN  = 10'b0000001000,
        ST_SDIV  = 10'b0000010000,
        ST_APPLY = 10'b0000100000,
        ST_ADIV  = 10'b0001000000,
        ST_EMIT  = 10'b0010000000,
        ST_QMUL  = 10'b0100000000,
        ST_QOUT  = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic req;
        logic adv;
        logic qlatch;
        logic mul;
        logic add;
        logic clr_exp;
        logic set_exp;
        logic div_start;
        logic div_src_new;
        logic wr_due;
        logic apply_sched;
        logic apply_del;
        logic pend_clr;
        logic qmul;
        logic load_exp;
        logic load_q;
        logic use_q;
    } cmd_t;

    typedef struct packed {
        logic       hit;
        logic       rep;
        logic       valid;
        logic [1:0] pend;
        logic       div_done;
        logic       exp_any;
        logic       exp_last;
        logic       out_free;
    } sts_t;
endpackage
`default_nettype wire

[rtl/htw_div.sv]
// Restoring divider: delay over tick length, one quotient bit per cycle.
`default_nettype none
module htw_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [htw_pkg::DelayW-1:0]  dividend,
    input  wire logic [htw_pkg::TickW-1:0]   divisor,
    output logic                             busy,
    output logic                             done,
    output logic [htw_pkg::DelayW-1:0]       quotient
);
    localparam int CntW = $clog2(htw_pkg::DelayW);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CntW-1:0]             cnt_reg;
    logic [htw_pkg::TickW-1:0]   rem_reg;
    logic [htw_pkg::DelayW-1:0]  quo_reg;
    logic [htw_pkg::TickW-1:0]   dvs_reg;
    logic [htw_pkg::TickW:0]     trial;
    logic                        fits;

    assign trial = {rem_reg, quo_reg[htw_pkg::DelayW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(htw_pkg::DelayW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? htw_pkg::TickW'(trial - {1'b0, dvs_reg})
                            : trial[htw_pkg::TickW-1:0];
            quo_reg <= {quo_reg[htw_pkg::DelayW-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

[rtl/htw_dp.sv]
// Datapath: wheel position, timer table, divider, query multiply and output register.
`default_nettype none
`include "assert_macros.svh"
module htw_dp #(
    parameter int MAX_TIMERS      = htw_pkg::MaxTimers,
    parameter int MAX_WHEEL_SLOTS = htw_pkg::MaxWheelSlots,
    parameter int IW              = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [0:0]            cfg_addr,
    input  wire logic [15:0]           cfg_wdata,
    input  wire logic [3:0]            timer_id,
    input  wire logic [23:0]           interval,
    input  wire logic                  recurring,
    input  wire logic [2:0]            op,
    input  wire htw_pkg::cmd_t         cmd,
    input  wire logic [IW-1:0]         idx,
    output htw_pkg::sts_t              sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [47:0]                m_tdata,
    output logic [0:0]                 m_tuser,
    output logic                       m_tlast
);
    localparam int SW = $clog2(MAX_WHEEL_SLOTS);
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int DW = htw_pkg::DelayW;

    logic [htw_pkg::SizeW-1:0]  wsize_reg;
    logic [htw_pkg::TickW-1:0]  tick_reg;
    logic [SW-1:0]              slot_reg;
    logic [31:0]                cycle_reg;
    logic [31:0]                prod_reg;
    logic [31:0]                now_reg;
    logic [CW-1:0]              count_reg;
    logic [MAX_TIMERS-1:0]      valid_reg;
    logic [MAX_TIMERS-1:0]      repeat_reg;
    logic [MAX_TIMERS-1:0]      exp_reg;
    logic [1:0]                 pend_reg [MAX_TIMERS];
    logic [DW-1:0]              ndelay_reg [MAX_TIMERS];
    logic [DW-1:0]              delay_reg [MAX_TIMERS];
    logic [31:0]                due_reg [MAX_TIMERS];
    logic [3:0]                 qid_reg;
    logic [31:0]                rem_reg;
    logic                       out_valid_reg;
    logic                       out_kind_reg;
    logic                       out_last_reg;
    logic [3:0]                 out_id_reg;
    logic [31:0]                out_rem_reg;
    logic [4:0]                 out_cnt_reg;

    logic [htw_pkg::SizeW-1:0]  eff_size;
    logic [htw_pkg::TickW-1:0]  eff_tick;
    logic [SW:0]                slot_plus;
    logic [IW-1:0]              wi;
    logic [IW-1:0]              ri;
    logic                       wr_ok;
    logic                       q_ok;
    logic                       div_busy;
    logic                       div_done;
    logic [DW-1:0]              div_q;
    logic [DW-1:0]              ticks;
    logic [31:0]                due_new;
    logic [IW-1:0]              first_idx;
    logic [MAX_TIMERS-1:0]      exp_rest;
    logic                       out_free;

    assign eff_size = (wsize_reg == '0) ? htw_pkg::SizeW'(1)
                    : (32'(wsize_reg) > 32'(MAX_WHEEL_SLOTS))
                      ? htw_pkg::SizeW'(MAX_WHEEL_SLOTS) : wsize_reg;
    assign eff_tick  = (tick_reg == '0) ? htw_pkg::TickW'(1) : tick_reg;
    assign slot_plus = {1'b0, slot_reg} + 1'b1;
    assign wi        = IW'(timer_id);
    assign wr_ok     = 32'(timer_id) < 32'(MAX_TIMERS);
    assign q_ok      = 32'(qid_reg) < 32'(MAX_TIMERS);
    assign ri        = cmd.use_q ? IW'(qid_reg) : idx;
    assign ticks     = (div_q == '0) ? DW'(1) : div_q;
    assign due_new   = now_reg + 32'(ticks);
    assign out_free  = !out_valid_reg || m_tready;

    htw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (cmd.div_src_new ? ndelay_reg[ri] : delay_reg[ri]),
        .divisor  (eff_tick),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // lowest pending expiry goes out first
    always_comb
    begin
        first_idx = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (exp_reg[i])
                first_idx = IW'(i);
        end
        exp_rest = exp_reg;
        exp_rest[first_idx] = 1'b0;
    end

    always_comb
    begin
        sts.hit      = valid_reg[ri] && (due_reg[ri] == now_reg);
        sts.rep      = repeat_reg[ri];
        sts.valid    = valid_reg[ri];
        sts.pend     = pend_reg[ri];
        sts.div_done = div_done;
        sts.exp_any  = exp_reg != '0;
        sts.exp_last = exp_rest == '0;
        sts.out_free = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg     <= htw_pkg::WheelSizeReset;
            tick_reg      <= htw_pkg::TickReset;
            slot_reg      <= '0;
            cycle_reg     <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            repeat_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TIMERS; i++)
                pend_reg[i] <= htw_pkg::PEND_NONE;
        end
        else
        begin
            if (cfg_we && cfg_addr == htw_pkg::REG_SLOT_COUNT)
                wsize_reg <= cfg_wdata[htw_pkg::SizeW-1:0];
            if (cfg_we && cfg_addr == htw_pkg::REG_TICK_INTERVAL)
                tick_reg <= cfg_wdata;
            if (cmd.adv)
            begin
                if (32'(slot_plus) >= 32'(eff_size))
                begin
                    slot_reg  <= '0;
                    cycle_reg <= cycle_reg + 1'b1;
                end
                else
                    slot_reg <= slot_plus[SW-1:0];
            end
            if (cmd.req && wr_ok)
            begin
                case (op)
                    htw_pkg::OP_CREATE:
                    begin
                        pend_reg[wi]   <= htw_pkg::PEND_CREATE;
                        repeat_reg[wi] <= recurring;
                    end
                    htw_pkg::OP_RESCHED:
                    begin
                        if (pend_reg[wi] != htw_pkg::PEND_CREATE)
                            pend_reg[wi] <= htw_pkg::PEND_RESCHED;
                    end
                    htw_pkg::OP_DELETE:
                        pend_reg[wi] <= htw_pkg::PEND_DELETE;
                    default:
                        ;
                endcase
            end
            if (cmd.apply_sched)
            begin
                pend_reg[ri] <= htw_pkg::PEND_NONE;
                if (!valid_reg[ri])
                begin
                    valid_reg[ri] <= 1'b1;
                    count_reg     <= count_reg + 1'b1;
                end
            end
            if (cmd.apply_del)
            begin
                pend_reg[ri] <= htw_pkg::PEND_NONE;
                if (valid_reg[ri])
                begin
                    valid_reg[ri] <= 1'b0;
                    count_reg     <= count_reg - 1'b1;
                end
            end
            if (cmd.pend_clr)
                pend_reg[ri] <= htw_pkg::PEND_NONE;
            if (cmd.load_exp || cmd.load_q)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req && wr_ok)
        begin
            case (op)
                htw_pkg::OP_CREATE,
                htw_pkg::OP_RESCHED: ndelay_reg[wi] <= interval;
                htw_pkg::OP_DELETE:  ndelay_reg[wi] <= '0;
                default:             ;
            endcase
        end
        if (cmd.qlatch)
            qid_reg <= timer_id;
        if (cmd.mul)
            prod_reg <= cycle_reg * 32'(eff_size);
        if (cmd.add)
            now_reg <= prod_reg + 32'(slot_reg);
        if (cmd.clr_exp)
            exp_reg <= '0;
        else if (cmd.set_exp)
            exp_reg[idx] <= 1'b1;
        else if (cmd.load_exp)
            exp_reg <= exp_rest;
        if (cmd.wr_due)
            due_reg[ri] <= due_new;
        if (cmd.apply_sched)
        begin
            delay_reg[ri] <= ndelay_reg[ri];
            due_reg[ri]   <= due_new;
        end
        if (cmd.qmul)
        begin
            if (!q_ok)
                rem_reg <= '0;
            else if (pend_reg[ri] == htw_pkg::PEND_CREATE ||
                     pend_reg[ri] == htw_pkg::PEND_RESCHED)
                rem_reg <= 32'(ndelay_reg[ri]);
            else if (valid_reg[ri])
                rem_reg <= (due_reg[ri] - now_reg) * 32'(eff_tick);
            else
                rem_reg <= '0;
        end
        // count travels with the item so a later tick cannot change a waiting result
        if (cmd.load_exp)
        begin
            out_kind_reg <= 1'b0;
            out_id_reg   <= 4'(first_idx);
            out_rem_reg  <= '0;
            out_cnt_reg  <= 5'(count_reg);
            out_last_reg <= exp_rest == '0;
        end
        else if (cmd.load_q)
        begin
            out_kind_reg <= 1'b1;
            out_id_reg   <= qid_reg;
            out_rem_reg  <= rem_reg;
            out_cnt_reg  <= 5'(count_reg);
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_cnt_reg, out_rem_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `HTW_ASSERT_ALWAYS(a_count_max, 32'(count_reg) <= 32'(MAX_TIMERS))
    `HTW_ASSERT_IMPLY(a_div_idle, cmd.div_start, !div_busy)
    `HTW_ASSERT_IMPLY(a_load_free, cmd.load_exp || cmd.load_q, out_free)
endmodule
`default_nettype wire

[rtl/htw_ctrl.sv]
// Controller: sequences tick scan, pending apply, expiry emission and queries.
`default_nettype none
`include "assert_macros.svh"
module htw_ctrl #(
    parameter int MAX_TIMERS = htw_pkg::MaxTimers,
    parameter int IW         = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [2:0]    op,
    input  wire htw_pkg::sts_t sts,
    output htw_pkg::cmd_t      cmd,
    output logic [IW-1:0]      idx
);
    htw_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            qmode_reg, qmode_next;
    logic            accept;
    logic            idx_end;

    assign accept  = s_tvalid && (state_reg == htw_pkg::ST_IDLE);
    assign idx_end = idx_reg == IW'(MAX_TIMERS - 1);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        qmode_next = qmode_reg;
        cmd        = '0;
        cmd.use_q  = qmode_reg;
        case (state_reg)
            htw_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (op)
                        htw_pkg::OP_TICK:
                        begin
                            cmd.adv    = 1'b1;
                            qmode_next = 1'b0;
                            state_next = htw_pkg::ST_MUL;
                        end
                        htw_pkg::OP_QUERY:
                        begin
                            cmd.qlatch = 1'b1;
                            qmode_next = 1'b1;
                            state_next = htw_pkg::ST_MUL;
                        end
                        default:
                            cmd.req = 1'b1;
                    endcase
                end
            end
            htw_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = htw_pkg::ST_ADD;
            end
            htw_pkg::ST_ADD:
            begin
                cmd.add     = 1'b1;
                cmd.clr_exp = !qmode_reg;
                idx_next    = '0;
                state_next  = qmode_reg ? htw_pkg::ST_QMUL : htw_pkg::ST_SCAN;
            end
            htw_pkg::ST_SCAN:
            begin
                if (sts.hit)
                    cmd.set_exp = 1'b1;
                if (sts.hit && sts.rep)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = htw_pkg::ST_SDIV;
                end
                else
                begin
                    idx_next   = idx_end ? '0 : idx_reg + 1'b1;
                    state_next = idx_end ? htw_pkg::ST_APPLY : htw_pkg::ST_SCAN;
                end
            end
            htw_pkg::ST_SDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.wr_due = 1'b1;
                    idx_next   = idx_end ? '0 : idx_reg + 1'b1;
                    state_next = idx_end ? htw_pkg::ST_APPLY : htw_pkg::ST_SCAN;
                end
            end
            htw_pkg::ST_APPLY:
            begin
                if (sts.pend == htw_pkg::PEND_CREATE ||
                    (sts.pend == htw_pkg::PEND_RESCHED && sts.valid))
                begin
                    cmd.div_start   = 1'b1;
                    cmd.div_src_new = 1'b1;
                    state_next      = htw_pkg::ST_ADIV;
                end
                else
                begin
                    // delete, a reschedule of an idle entry that is dropped, or nothing pending
                    cmd.apply_del = sts.pend == htw_pkg::PEND_DELETE;
                    cmd.pend_clr  = sts.pend == htw_pkg::PEND_RESCHED;
                    idx_next      = idx_reg + 1'b1;
                    if (idx_end)
                        state_next = sts.exp_any ? htw_pkg::ST_EMIT : htw_pkg::ST_IDLE;
                end
            end
            htw_pkg::ST_ADIV:
            begin
                cmd.div_src_new = 1'b1;
                if (sts.div_done)
                begin
                    cmd.apply_sched = 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    if (idx_end)
                        state_next = sts.exp_any ? htw_pkg::ST_EMIT : htw_pkg::ST_IDLE;
                    else
                        state_next = htw_pkg::ST_APPLY;
                end
            end
            htw_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_exp = 1'b1;
                    if (sts.exp_last)
                        state_next = htw_pkg::ST_IDLE;
                end
            end
            htw_pkg::ST_QMUL:
            begin
                cmd.qmul   = 1'b1;
                state_next = htw_pkg::ST_QOUT;
            end
            htw_pkg::ST_QOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_q = 1'b1;
                    state_next = htw_pkg::ST_IDLE;
                end
            end
            default:
                state_next = htw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= htw_pkg::ST_IDLE;
            idx_reg   <= '0;
            qmode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            qmode_reg <= qmode_next;
        end
    end

    assign s_tready = state_reg == htw_pkg::ST_IDLE;
    assign idx      = idx_reg;

    `HTW_ASSERT_IMPLY(a_emit_has_item, state_reg == htw_pkg::ST_EMIT, sts.exp_any)
    `HTW_ASSERT_NEXT(a_tick_starts, accept && op == htw_pkg::OP_TICK,
                     state_reg == htw_pkg::ST_MUL)
    `HTW_ASSERT_IMPLY(a_wait_div, state_reg == htw_pkg::ST_SDIV ||
                      state_reg == htw_pkg::ST_ADIV, !cmd.div_start)
endmodule
`default_nettype wire

[rtl/hashed_timing_wheel_top.sv]
// Top level of the hashed timing wheel: controller, datapath and stream ports.
// Usage:
//   Input items arrive on s_tvalid/s_tready; s_tuser carries the op code.
//   Create, reschedule and delete are accepted while idle and only marked
//   pending. A query forms the current slot, computes the remaining time of
//   the timer and returns one item on the m_ channel once the output
//   register is free. A tick forms the current slot, scans every entry and
//   applies pending requests, waiting on the shared serial divider for each
//   rearmed or newly scheduled entry, then sends one item per expiry.
//   Expiries come out in entry order, m_tlast set on the final one; a tick
//   with no expiry gives no item. s_tready is low while a tick or query runs.
//   A stalled m_tready holds the output register and the emission sequence;
//   a new item is still taken while the last result waits to be read.
//   Reset clears the wheel position, all timers and pending requests, and
//   sets the slot count to 60 and tick_interval to 1. Write cfg_* only when idle.
`default_nettype none
module hashed_timing_wheel_top #(
    parameter int MAX_TIMERS      = htw_pkg::MaxTimers,
    parameter int MAX_WHEEL_SLOTS = htw_pkg::MaxWheelSlots
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // timer_id[3:0], interval[27:4], recurring[28]
    input  wire logic [2:0]  s_tuser,   // op[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // timer_out[3:0], remaining[35:4], active_count[40:36]
    output logic [0:0]       m_tuser,   // kind[0]
    output logic             m_tlast
);
    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    htw_pkg::cmd_t cmd;
    htw_pkg::sts_t sts;
    logic [IW-1:0] idx;

    htw_ctrl #(
        .MAX_TIMERS (MAX_TIMERS),
        .IW         (IW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .sts      (sts),
        .cmd      (cmd),
        .idx      (idx)
    );

    htw_dp #(
        .MAX_TIMERS      (MAX_TIMERS),
        .MAX_WHEEL_SLOTS (MAX_WHEEL_SLOTS),
        .IW              (IW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .timer_id  (s_tdata[3:0]),
        .interval  (s_tdata[27:4]),
        .recurring (s_tdata[28]),
        .op        (s_tuser),
        .cmd       (cmd),
        .idx       (idx),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );
endmodule
`default_nettype wire
